/* rtl/cdsg_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the subset gather block.
package cdsg_pkg;

    // Storage dimensions.
    localparam int MAX_POINTS   = 256;
    localparam int MAX_SELECTED = 64;
    localparam int STORE_DEPTH  = (MAX_POINTS * (MAX_POINTS - 1)) / 2;

    // Field and register widths.
    localparam int KIND_W     = 2;
    localparam int POS_W      = 15;
    localparam int WORD_W     = 64;
    localparam int SLOT_W     = 6;
    localparam int POINT_W    = 8;
    localparam int PAIR_W     = 11;
    localparam int STATUS_W   = 2;
    localparam int NP_W       = 9;
    localparam int NS_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Internal arithmetic widths.
    localparam int ROW_W   = 7;
    localparam int J_W     = 14;
    localparam int PAIRS_W = 13;
    localparam int PROD_W  = NP_W + POINT_W;
    localparam int TRI_W   = 2 * (POINT_W + 1);
    localparam int SUM_W   = TRI_W + 1;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD_DIST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_SEL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY     = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PAIR_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_POINT_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd3;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SELECTED = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [NP_W-1:0] NUM_POINTS_RST   = 9'd2;
    localparam logic [NS_W-1:0] NUM_SELECTED_RST = 7'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic search_step;
        logic sel_read;
        logic order;
        logic mult;
        logic sum;
        logic mem_read;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic last;
        logic err;
    } stat_t;

endpackage

/* rtl/condensed_distance_subset_gather.sv */
// Top level of the condensed distance subset gather block: controller plus datapath.
//
// Distance and selection loads are taken in the idle state and give no result. A
// query runs the row search, which tests one row per cycle on a single incremental
// adder from row 0 up to the subset row of the pair (0 to MAX_SELECTED-2), and then
// the two-port selection table read, sorting, the address multiplies, the
// subtraction, the registered distance store read and the output load. A query whose
// pair index is out of range skips the search and goes straight to the output load.
// A finished result waits in an output register, and the block takes further items
// while it waits; only a second query's result stalls until the first is taken.
// There is no clearing pass after reset.
module condensed_distance_subset_gather
    import cdsg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [KIND_W-1:0]     kind,
    input  logic [POS_W-1:0]      entry_position,
    input  logic [WORD_W-1:0]     distance_bits,
    input  logic [SLOT_W-1:0]     slot,
    input  logic [POINT_W-1:0]    point,
    input  logic [PAIR_W-1:0]     pair_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WORD_W-1:0]     result_bits,
    output logic [STATUS_W-1:0]   status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    cdsg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cdsg_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .kind           (kind),
        .entry_position (entry_position),
        .distance_bits  (distance_bits),
        .slot           (slot),
        .point          (point),
        .pair_index     (pair_index),
        .result_bits    (result_bits),
        .status         (status)
    );

endmodule

/* rtl/cdsg_ctrl.sv */
// Controller state machine sequencing loads and query steps, plus the output valid flag.
module cdsg_ctrl
    import cdsg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    output logic              out_valid,
    input  logic              out_ready,
    input  stat_t             stat,
    output cmd_t              cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SEL_RD = 3'd2;
    localparam logic [2:0] S_ORDER  = 3'd3;
    localparam logic [2:0] S_MULT   = 3'd4;
    localparam logic [2:0] S_SUM    = 3'd5;
    localparam logic [2:0] S_MEM_RD = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid && (kind == KIND_QUERY))
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.err)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                    if (stat.hit)
                    begin
                        state_next = S_SEL_RD;
                    end
                    else if (stat.last)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SEL_RD:
            begin
                cmd.sel_read = 1'b1;
                state_next   = S_ORDER;
            end
            S_ORDER:
            begin
                cmd.order  = 1'b1;
                state_next = S_MULT;
            end
            S_MULT:
            begin
                if (stat.err)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mult   = 1'b1;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_MEM_RD;
            end
            S_MEM_RD:
            begin
                cmd.mem_read = !stat.err;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output holding register is full from a load until its transaction completes.
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_search_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |->
            ($past(state_reg) == S_IDLE || $past(state_reg) == S_SEARCH))
        else $error("search entered from an unexpected state");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("pending result dropped");
`endif

endmodule

/* rtl/cdsg_datapath.sv */
// Datapath: configuration registers, stores, row search, address arithmetic and output register.
module cdsg_datapath
    import cdsg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [KIND_W-1:0]     kind,
    input  logic [POS_W-1:0]      entry_position,
    input  logic [WORD_W-1:0]     distance_bits,
    input  logic [SLOT_W-1:0]     slot,
    input  logic [POINT_W-1:0]    point,
    input  logic [PAIR_W-1:0]     pair_index,
    output logic [WORD_W-1:0]     result_bits,
    output logic [STATUS_W-1:0]   status
);

    logic [NP_W-1:0]     num_points_reg;
    logic [NS_W-1:0]     num_selected_reg;
    logic [NP_W-1:0]     n_eff;
    logic [NS_W-1:0]     m_eff;

    logic [WORD_W-1:0]   distance_store [STORE_DEPTH];
    logic [POINT_W-1:0]  selection_table [MAX_SELECTED];

    logic [ROW_W-1:0]    i_reg;
    logic signed [J_W-1:0] j_reg;
    logic signed [J_W-1:0] i_s;
    logic signed [J_W-1:0] m_s;
    logic [SLOT_W-1:0]   row_reg;
    logic [SLOT_W-1:0]   col_reg;
    logic [2*NS_W-1:0]   pair_prod;
    logic [PAIRS_W-1:0]  pairs;
    logic                bad_pair;

    logic [POINT_W-1:0]  a_rd_reg;
    logic [POINT_W-1:0]  b_rd_reg;
    logic [POINT_W-1:0]  lo_reg;
    logic [POINT_W-1:0]  hi_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [TRI_W-1:0]    tri_reg;
    logic signed [SUM_W-1:0] addr_s;
    logic [POS_W-1:0]    addr_reg;
    logic [WORD_W-1:0]   rdata_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [WORD_W-1:0]   result_bits_reg;
    logic [STATUS_W-1:0] status_out_reg;

    // Configuration registers; the user must write them only while the block is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg   <= NUM_POINTS_RST;
            num_selected_reg <= NUM_SELECTED_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_NUM_POINTS)
            begin
                num_points_reg <= cfg_data;
            end
            else if (cfg_index == CFG_NUM_SELECTED)
            begin
                num_selected_reg <= cfg_data[NS_W-1:0];
            end
        end
    end

    // Oversized register values saturate at the storage limits.
    assign n_eff = (num_points_reg > NP_W'(MAX_POINTS)) ? NP_W'(MAX_POINTS) : num_points_reg;
    assign m_eff = (num_selected_reg > NS_W'(MAX_SELECTED)) ? NS_W'(MAX_SELECTED)
                                                             : num_selected_reg;

    // Number of subset pairs, checked as the query is taken.
    assign pair_prod = (2*NS_W)'(m_eff) * (2*NS_W)'(m_eff - NS_W'(1));
    assign pairs     = pair_prod[PAIRS_W:1];
    assign bad_pair  = (PAIRS_W'(pair_index) >= pairs);

    // Row search: the column for row i is tracked incrementally.
    assign i_s       = J_W'(i_reg);
    assign m_s       = J_W'(m_eff);
    assign stat.hit  = (i_s < j_reg) && (j_reg < m_s);
    assign stat.last = (i_reg == ROW_W'(m_eff - NS_W'(1)));
    assign stat.err  = (status_reg != ST_OK);

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            i_reg      <= '0;
            j_reg      <= J_W'(pair_index) + J_W'(1);
            status_reg <= bad_pair ? ST_PAIR_RANGE : ST_OK;
        end
        else if (cmd.search_step)
        begin
            if (stat.hit)
            begin
                row_reg <= i_reg[SLOT_W-1:0];
                col_reg <= j_reg[SLOT_W-1:0];
            end
            else if (stat.last)
            begin
                status_reg <= ST_PAIR_RANGE;
            end
            else
            begin
                i_reg <= i_reg + ROW_W'(1);
                j_reg <= j_reg + i_s + J_W'(2) - m_s;
            end
        end
        else if (cmd.order)
        begin
            if (((a_rd_reg > b_rd_reg) ? a_rd_reg : b_rd_reg) >= n_eff)
            begin
                status_reg <= ST_POINT_RANGE;
            end
            else if (a_rd_reg == b_rd_reg)
            begin
                status_reg <= ST_DUPLICATE;
            end
        end
        else if (cmd.sum)
        begin
            if ((addr_s < 0) || (addr_s >= SUM_W'(STORE_DEPTH)))
            begin
                status_reg <= ST_POINT_RANGE;
            end
        end
    end

    // Selection table: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.take && (kind == KIND_LOAD_SEL))
        begin
            selection_table[slot] <= point;
        end
        if (cmd.sel_read)
        begin
            a_rd_reg <= selection_table[row_reg];
            b_rd_reg <= selection_table[col_reg];
        end
    end

    // Sort the two global points, form the products of the address, then register the address sum.
    always_ff @(posedge clk)
    begin
        if (cmd.order)
        begin
            lo_reg <= (a_rd_reg > b_rd_reg) ? b_rd_reg : a_rd_reg;
            hi_reg <= (a_rd_reg > b_rd_reg) ? a_rd_reg : b_rd_reg;
        end
        if (cmd.mult)
        begin
            prod_reg <= PROD_W'(n_eff) * PROD_W'(lo_reg);
            tri_reg  <= TRI_W'((POINT_W + 1)'(lo_reg) + (POINT_W + 1)'(2))
                      * TRI_W'((POINT_W + 1)'(lo_reg) + (POINT_W + 1)'(1));
        end
        if (cmd.sum)
        begin
            addr_reg <= addr_s[POS_W-1:0];
        end
    end

    // Global condensed address n*a + b - (a+2)(a+1)/2.
    assign addr_s = SUM_W'(prod_reg) + SUM_W'(hi_reg) - SUM_W'(tri_reg[TRI_W-1:1]);

    // Distance store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.take && (kind == KIND_LOAD_DIST) && (entry_position < POS_W'(STORE_DEPTH)))
        begin
            distance_store[entry_position] <= distance_bits;
        end
        if (cmd.mem_read)
        begin
            rdata_reg <= distance_store[addr_reg];
        end
    end

    // Output holding register; the word is zero whenever the status reports a fault.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_bits_reg <= (status_reg == ST_OK) ? rdata_reg : '0;
            status_out_reg  <= status_reg;
        end
    end

    assign result_bits = result_bits_reg;
    assign status      = status_out_reg;

`ifndef ASSERT_OFF
    a_row_below_col: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.search_step && stat.hit) |=> (row_reg < col_reg))
        else $error("search found a column not above its row");

    a_sorted_points: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.order |=> (lo_reg <= hi_reg))
        else $error("global points not in ascending order");

    a_read_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_read |-> (status_reg == ST_OK))
        else $error("distance store read for a faulted query");
`endif

endmodule

/* verif/cdsg_gather_checker.sv */
// Checker for the subset gather block: predicts each query result and compares it.
`timescale 1ns / 100ps

module cdsg_gather_checker
    import cdsg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [KIND_W-1:0]     kind,
    input  logic [POS_W-1:0]      entry_position,
    input  logic [WORD_W-1:0]     distance_bits,
    input  logic [SLOT_W-1:0]     slot,
    input  logic [POINT_W-1:0]    point,
    input  logic [PAIR_W-1:0]     pair_index,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [WORD_W-1:0]     result_bits,
    input  logic [STATUS_W-1:0]   status,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    results_checked
);

    // One predicted query result.
    typedef struct packed {
        logic [WORD_W-1:0]   word;
        logic [STATUS_W-1:0] code;
    } gather_t;

    // Private copy of the block's storage and registers.
    logic [WORD_W-1:0]  dist_mem [STORE_DEPTH];
    logic [POINT_W-1:0] sel_mem  [MAX_SELECTED];
    logic [NP_W-1:0]    cfg_np;
    logic [NS_W-1:0]    cfg_ns;

    gather_t expected_gathers [$];
    gather_t head;
    int      errors;
    int      checked;

    // Works out the result of a query from the current table, store and registers.
    function automatic gather_t gather_lookup(input logic [PAIR_W-1:0] pair);
        int      m;
        int      n;
        int      k;
        int      pairs;
        int      row;
        int      col;
        int      i;
        int      j;
        int      a;
        int      b;
        int      t;
        int      addr;
        gather_t r;
        m     = (int'(cfg_ns) > MAX_SELECTED) ? MAX_SELECTED : int'(cfg_ns);
        n     = (int'(cfg_np) > MAX_POINTS) ? MAX_POINTS : int'(cfg_np);
        k     = int'(pair);
        pairs = (m * (m - 1)) / 2;
        row   = -1;
        col   = -1;
        r.word = '0;
        r.code = ST_PAIR_RANGE;
        if (k < pairs) begin
            // Find the first subset row whose column lands above the diagonal.
            for (i = 0; i < m; i++) begin
                j = k + ((i + 2) * (i + 1)) / 2 - m * i;
                if (row < 0 && i < j && j < m) begin
                    row = i;
                    col = j;
                end
            end
            if (row >= 0) begin
                a = int'(sel_mem[row]);
                b = int'(sel_mem[col]);
                if (a > b) begin
                    t = a;
                    a = b;
                    b = t;
                end
                if (b >= n) begin
                    r.code = ST_POINT_RANGE;
                end else if (a == b) begin
                    r.code = ST_DUPLICATE;
                end else begin
                    addr = n * a + b - ((a + 2) * (a + 1)) / 2;
                    if (addr < 0 || addr >= STORE_DEPTH) begin
                        r.code = ST_POINT_RANGE;
                    end else begin
                        r.word = dist_mem[addr];
                        r.code = ST_OK;
                    end
                end
            end
        end
        return r;
    endfunction

    // Watch the three channels at each rising edge.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_np = NUM_POINTS_RST;
            cfg_ns = NUM_SELECTED_RST;
            expected_gathers.delete();
            errors  = 0;
            checked = 0;
            fail_count      <= 0;
            pending         <= 0;
            results_checked <= 0;
        end else begin
            // Result transactions are matched against the oldest prediction.
            if (out_valid && out_ready) begin
                if (expected_gathers.size() == 0) begin
                    $display("%0t: result with no query outstanding: status %0d, bits %h",
                             $time, status, result_bits);
                    errors++;
                end else begin
                    head = expected_gathers.pop_front();
                    checked++;
                    if (status !== head.code) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, head.code, status);
                        errors++;
                    end
                    if (result_bits !== head.word) begin
                        $display("%0t: result_bits mismatch: expected %h, actual %h",
                                 $time, head.word, result_bits);
                        errors++;
                    end
                end
            end

            // Register write transactions.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NUM_POINTS:   cfg_np = cfg_data[NP_W-1:0];
                    CFG_NUM_SELECTED: cfg_ns = cfg_data[NS_W-1:0];
                    default: ;
                endcase
            end

            // Input transactions update the copy of the storage or raise a prediction.
            if (in_valid && in_ready) begin
                case (kind)
                    KIND_LOAD_DIST: begin
                        if (int'(entry_position) < STORE_DEPTH)
                            dist_mem[entry_position] = distance_bits;
                    end
                    KIND_LOAD_SEL: begin
                        if (int'(slot) < MAX_SELECTED)
                            sel_mem[slot] = point;
                    end
                    KIND_QUERY: expected_gathers.push_back(gather_lookup(pair_index));
                    default: ;
                endcase
            end

            fail_count      <= errors;
            pending         <= expected_gathers.size();
            results_checked <= checked;
        end
    end

endmodule

/* verif/testbench.sv */
// Top of the subset gather testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module testbench;
    import cdsg_pkg::*;

    // Item kind that the block ignores.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 110;
    localparam int SHORT_PHASE    = 40;
    localparam int RANDOM_PHASES  = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [KIND_W-1:0]     kind;
    logic [POS_W-1:0]      entry_position;
    logic [WORD_W-1:0]     distance_bits;
    logic [SLOT_W-1:0]     slot;
    logic [POINT_W-1:0]    point;
    logic [PAIR_W-1:0]     pair_index;
    logic                  out_valid;
    logic                  out_ready;
    logic [WORD_W-1:0]     result_bits;
    logic [STATUS_W-1:0]   status;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int results_checked;

    // What the stimulus has loaded so far, so that no query reads an empty entry.
    logic [POINT_W-1:0] slot_point   [MAX_SELECTED];
    bit                 slot_loaded  [MAX_SELECTED];
    bit                 entry_loaded [STORE_DEPTH];
    int                 cur_n;
    int                 cur_m;
    bit                 quiet;
    bit                 random_part;
    int                 idle_count = 0;
    int                 n_dist;
    int                 n_sel;
    int                 n_query;
    int                 n_other;
    int                 n_settings;

    condensed_distance_subset_gather dut (.*);

    cdsg_gather_checker gather_check (.*);

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: ends the run when no transaction has happened for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_count <= 0;
        end
        else if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, idle_count);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_count <= idle_count + 1;
        end
    end

    // Result back-pressure in random bursts; always ready in the quiet part.
    initial
    begin
        int burst;
        bit stall;
        out_ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                burst = $urandom_range(1, 15);
                stall = ($urandom_range(0, 2) == 0);
                out_ready <= !stall;
                repeat (burst) @(posedge clk);
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly points inside the current range, sometimes any point or a repeat of a loaded one.
    function automatic int pick_point();
        int r;
        int s;
        r = $urandom_range(0, 19);
        s = $urandom_range(0, MAX_SELECTED - 1);
        if (r == 0 && slot_loaded[s])
            return int'(slot_point[s]);
        else if (r < 4)
            return $urandom_range(0, (1 << POINT_W) - 1);
        else
            return $urandom_range(0, cur_n - 1);
    endfunction

    // Drives one input transaction, at times with a random gap before it, and waits for acceptance.
    task automatic send_item(input logic [KIND_W-1:0]  item_kind,
                             input logic [POS_W-1:0]   pos,
                             input logic [WORD_W-1:0]  word,
                             input logic [SLOT_W-1:0]  s,
                             input logic [POINT_W-1:0] pt,
                             input logic [PAIR_W-1:0]  pr);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= item_kind;
        entry_position <= pos;
        distance_bits  <= word;
        slot           <= s;
        point          <= pt;
        pair_index     <= pr;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        case (item_kind)
            KIND_LOAD_DIST:
            begin
                if (int'(pos) < STORE_DEPTH)
                    entry_loaded[pos] = 1'b1;
                n_dist++;
            end
            KIND_LOAD_SEL:
            begin
                slot_point[s]  = pt;
                slot_loaded[s] = 1'b1;
                n_sel++;
            end
            KIND_QUERY: n_query++;
            default:    n_other++;
        endcase
    endtask

    task automatic load_dist(input int pos, input logic [WORD_W-1:0] word);
        send_item(KIND_LOAD_DIST, pos[POS_W-1:0], word, SLOT_W'($urandom),
                  POINT_W'($urandom), PAIR_W'($urandom));
    endtask

    task automatic load_sel(input int s, input int pt);
        send_item(KIND_LOAD_SEL, POS_W'($urandom), rand_word(), s[SLOT_W-1:0],
                  pt[POINT_W-1:0], PAIR_W'($urandom));
    endtask

    task automatic send_query(input int k);
        send_item(KIND_QUERY, POS_W'($urandom), rand_word(), SLOT_W'($urandom),
                  POINT_W'($urandom), k[PAIR_W-1:0]);
    endtask

    task automatic send_unused();
        send_item(KIND_UNUSED, POS_W'($urandom), rand_word(), SLOT_W'($urandom),
                  POINT_W'($urandom), PAIR_W'($urandom));
    endtask

    // Query for subset row i and column j, loading first whatever the query will read.
    task automatic query_pair(input int i, input int j);
        int a;
        int b;
        int t;
        int addr;
        if (!slot_loaded[i] || (random_part && $urandom_range(0, 9) == 0))
            load_sel(i, pick_point());
        if (!slot_loaded[j] || (random_part && $urandom_range(0, 9) == 0))
            load_sel(j, pick_point());
        a = int'(slot_point[i]);
        b = int'(slot_point[j]);
        if (a > b)
        begin
            t = a;
            a = b;
            b = t;
        end
        if (b < cur_n && a != b)
        begin
            addr = cur_n * a + b - ((a + 2) * (a + 1)) / 2;
            if (!entry_loaded[addr] || (random_part && $urandom_range(0, 7) == 0))
                load_dist(addr, rand_word());
        end
        send_query(cur_m * i - (i * (i + 1)) / 2 + (j - i - 1));
    endtask

    // Holds off the sender until every outstanding query result has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Writes both registers once the block is idle.
    task automatic apply_setting(input int np, input int ns);
        int v;
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_NUM_POINTS;
        cfg_data  <= np[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= CFG_NUM_SELECTED;
        cfg_data  <= ns[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        v = np & ((1 << NP_W) - 1);
        cur_n = (v > MAX_POINTS) ? MAX_POINTS : v;
        v = ns & ((1 << NS_W) - 1);
        cur_m = (v > MAX_SELECTED) ? MAX_SELECTED : v;
        n_settings++;
    endtask

    // One random item: mostly well-formed queries, the rest loads and noise.
    task automatic random_item();
        int r;
        int i;
        int j;
        int pairs;
        if (!quiet && $urandom_range(0, 59) == 0)
            wait_idle();
        r = $urandom_range(0, 99);
        pairs = (cur_m * (cur_m - 1)) / 2;
        if (r < 55 && cur_m >= 2)
        begin
            i = $urandom_range(0, cur_m - 2);
            j = $urandom_range(i + 1, cur_m - 1);
            query_pair(i, j);
        end
        else if (r < 75)
        begin
            load_sel($urandom_range(0, MAX_SELECTED - 1), pick_point());
        end
        else if (r < 87)
        begin
            load_dist($urandom_range(0, (1 << POS_W) - 1), rand_word());
        end
        else if (r < 95)
        begin
            send_query($urandom_range(pairs, (1 << PAIR_W) - 1));
        end
        else
        begin
            send_unused();
        end
    endtask

    // Main stimulus and verdict.
    initial
    begin
        int p;
        int it;
        int np;
        int ns;
        int count;
        in_valid       = 1'b0;
        kind           = '0;
        entry_position = '0;
        distance_bits  = '0;
        slot           = '0;
        point          = '0;
        pair_index     = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        quiet          = 1'b0;
        random_part    = 1'b0;
        cur_n          = NUM_POINTS_RST;
        cur_m          = NUM_SELECTED_RST;
        n_dist = 0;
        n_sel = 0;
        n_query = 0;
        n_other = 0;
        n_settings = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset setting: the smallest matrix and subset.
        load_sel(0, 1);
        load_sel(1, 0);
        load_dist(0, '1);
        query_pair(0, 1);
        send_query(1);
        send_item(KIND_UNUSED, '1, '1, '1, '1, '1);
        load_dist(STORE_DEPTH, rand_word());
        load_dist((1 << POS_W) - 1, '0);

        // Largest matrix and subset: last pair, last entry, duplicate point.
        apply_setting(MAX_POINTS, MAX_SELECTED);
        load_sel(MAX_SELECTED - 1, (1 << POINT_W) - 1);
        load_sel(MAX_SELECTED - 2, 0);
        load_dist(254, '0);
        query_pair(MAX_SELECTED - 2, MAX_SELECTED - 1);
        load_sel(4, 254);
        load_dist(STORE_DEPTH - 1, 64'h8000_0000_0000_0001);
        query_pair(4, MAX_SELECTED - 1);
        load_sel(5, (1 << POINT_W) - 1);
        query_pair(5, MAX_SELECTED - 1);
        send_query(2016);
        query_pair(0, MAX_SELECTED - 1);

        // Oversized register values, and points that arrive in descending order.
        apply_setting((1 << CFG_DATA_W) - 1, (1 << CFG_DATA_W) - 1);
        query_pair(0, MAX_SELECTED - 2);

        // Small matrix: point out of range, and range taking precedence over duplicates.
        apply_setting(10, 9'h185);
        query_pair(0, 1);
        load_sel(2, 200);
        query_pair(1, 2);
        load_sel(3, 200);
        query_pair(2, 3);
        send_query(10);

        // Random part over several settings; the last one runs without idling.
        random_part = 1'b1;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    np = MAX_POINTS;
                    ns = MAX_SELECTED;
                end
                1:
                begin
                    np = 2;
                    ns = MAX_SELECTED;
                end
                2:
                begin
                    np = (1 << NP_W) - 1;
                    ns = (1 << NS_W) - 1;
                end
                3:
                begin
                    np = $urandom_range(3, 255);
                    ns = $urandom_range(2, 20);
                end
                4:
                begin
                    np = $urandom_range(2, 9);
                    ns = 2;
                end
                5:
                begin
                    np = MAX_POINTS;
                    ns = 1;
                end
                6:
                begin
                    np = 300;
                    ns = 0;
                end
                default:
                begin
                    np = $urandom_range(100, MAX_POINTS);
                    ns = $urandom_range(30, MAX_SELECTED);
                end
            endcase
            // Upper data bits are dropped by the narrower register.
            ns = ns | ($urandom_range(0, 3) << NS_W);
            apply_setting(np, ns);
            if (p == RANDOM_PHASES - 1)
                quiet = 1'b1;
            count = (cur_m < 2) ? SHORT_PHASE : PHASE_ITEMS;
            for (it = 0; it < count; it++)
                random_item();
        end

        // Drain and let the block settle.
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d distance loads, %0d selection loads, %0d queries",
                 n_dist, n_sel, n_query);
        $display("and %0d ignored items over %0d register settings; %0d results compared.",
                 n_other, n_settings, results_checked);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
